// ===== rtl/rom_ram_bank_mapper_defines.svh =====
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_defines: assertion macros
// Shared assertion forms for the bank mapper checker.
// ----------------------------------------------------------------------------
`ifndef ROM_RAM_BANK_MAPPER_DEFINES_SVH
`define ROM_RAM_BANK_MAPPER_DEFINES_SVH

// Assertion that is disabled while reset is asserted.
`define RBM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rom_ram_bank_mapper assertion failed");

// Assertion that is also checked during reset.
`define RBM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rom_ram_bank_mapper reset assertion failed");

`endif

// ===== rtl/rbm_pkg.sv =====
// ----------------------------------------------------------------------------
// rbm_pkg: bank mapper definitions
// Field widths, address decode constants, action codes and shared types.
// ----------------------------------------------------------------------------
package rbm_pkg;

  localparam int RBM_ROM_ADDR_BITS = 20;
  localparam int RBM_RAM_ADDR_BITS = 17;

  localparam int ACTION_W  = 3;
  localparam int BUS_W     = 16;
  localparam int DATA_W    = 8;
  localparam int LOAD_W    = 20;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam int ROM_POS_W = 23;
  localparam int RAM_POS_W = 17;

  localparam logic [BUS_W-1:0] ADDR_RAM_EN_END  = 16'h2000;
  localparam logic [BUS_W-1:0] ADDR_ROM_LOW_END = 16'h3000;
  localparam logic [BUS_W-1:0] ADDR_ROM_HI_END  = 16'h4000;
  localparam logic [BUS_W-1:0] ADDR_RAM_BK_END  = 16'h6000;

  localparam logic [3:0]        RAM_EN_KEY    = 4'hA;
  localparam logic [DATA_W-1:0] RAM_OFF_DATA  = 8'hFF;
  localparam logic [DATA_W-1:0] ZERO_DATA     = 8'h00;
  localparam int                RUMBLE_BIT    = 3;

  localparam logic [CFG_W-1:0] ROM_LOG2_RESET = 5'd20;
  localparam logic [CFG_W-1:0] RAM_LOG2_RESET = 5'd17;
  localparam logic [7:0]       ROM_LOW_RESET  = 8'h01;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROM_SIZE_LOG2 = 2'd0,
    CFG_RAM_SIZE_LOG2 = 2'd1,
    CFG_HAS_RUMBLE    = 2'd2
  } cfg_index_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REG_WRITE = 3'd0,
    ACT_ROM_READ  = 3'd1,
    ACT_RAM_READ  = 3'd2,
    ACT_RAM_WRITE = 3'd3,
    ACT_ROM_LOAD  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_ROM,
    SEL_RAM,
    SEL_OFF
  } rd_sel_t;

  typedef struct packed {
    logic [3:0] ram_enable;
    logic [7:0] rom_bank_low;
    logic       rom_bank_high;
    logic [3:0] ram_bank;
  } bank_state_t;

endpackage

// ===== rtl/rbm_if.sv =====
// ----------------------------------------------------------------------------
// rbm_in_if / rbm_out_if: bank mapper channels
// Valid/ready channels for bus accesses and their results.
// ----------------------------------------------------------------------------
interface rbm_in_if;
  import rbm_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BUS_W-1:0]    bus_address;
  logic [DATA_W-1:0]   write_data;
  logic [LOAD_W-1:0]   load_index;

  modport source (output valid, action, bus_address, write_data, load_index, input ready);
  modport sink   (input valid, action, bus_address, write_data, load_index, output ready);
endinterface

interface rbm_out_if;
  import rbm_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              motor_on;

  modport source (output valid, read_data, motor_on, input ready);
  modport sink   (input valid, read_data, motor_on, output ready);
endinterface

// ===== rtl/rbm_regs.sv =====
// ----------------------------------------------------------------------------
// rbm_regs: bank register file
// Decodes register writes by bus address into the enable and bank registers.
// ----------------------------------------------------------------------------
module rbm_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [rbm_pkg::BUS_W-1:0]  bus_address,
  input  logic [rbm_pkg::DATA_W-1:0] write_data,
  output rbm_pkg::bank_state_t       bank
);
  import rbm_pkg::*;

  bank_state_t bank_r;
  bank_state_t bank_nxt;

  always_comb begin
    bank_nxt = bank_r;
    if (wr_en) begin
      if (bus_address < ADDR_RAM_EN_END) begin
        bank_nxt.ram_enable = write_data[3:0];
      end else if (bus_address < ADDR_ROM_LOW_END) begin
        bank_nxt.rom_bank_low = write_data;
      end else if (bus_address < ADDR_ROM_HI_END) begin
        bank_nxt.rom_bank_high = write_data[0];
      end else if (bus_address < ADDR_RAM_BK_END) begin
        bank_nxt.ram_bank = write_data[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r.ram_enable    <= '0;
      bank_r.rom_bank_low  <= ROM_LOW_RESET;
      bank_r.rom_bank_high <= 1'b0;
      bank_r.ram_bank      <= '0;
    end else begin
      bank_r <= bank_nxt;
    end
  end

  assign bank = bank_r;

endmodule

// ===== rtl/rom_ram_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper: cartridge ROM/RAM bank controller
// A result is valid in the cycle after its transaction (memory read port).
// Throughput: one transaction per cycle while results are taken.
// Reset clears the RAM one entry a cycle, all 2**RAM_ADDR_BITS entries (131072),
// with no input accepted; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module rom_ram_bank_mapper #(
  parameter int ROM_ADDR_BITS = rbm_pkg::RBM_ROM_ADDR_BITS,
  parameter int RAM_ADDR_BITS = rbm_pkg::RBM_RAM_ADDR_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rbm_in_if.sink                        in_ch,
  rbm_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [rbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbm_pkg::CFG_W-1:0]     cfg_data
);
  import rbm_pkg::*;

  localparam int ROM_DEPTH = 1 << ROM_ADDR_BITS;
  localparam int RAM_DEPTH = 1 << RAM_ADDR_BITS;
  localparam int LOAD_EXT_W = (ROM_ADDR_BITS > LOAD_W) ? ROM_ADDR_BITS : LOAD_W;

  logic [CFG_W-1:0] rom_size_log2_r;
  logic [CFG_W-1:0] ram_size_log2_r;
  logic             has_rumble_r;

  logic                     clearing_r;
  logic [RAM_ADDR_BITS-1:0] clear_cnt_r;

  logic    s1_valid_r;
  rd_sel_t s1_sel_r;
  rd_sel_t sel_nxt;

  logic [DATA_W-1:0] rom_mem [ROM_DEPTH];
  logic [DATA_W-1:0] ram_mem [RAM_DEPTH];
  logic [DATA_W-1:0] rom_q_r;
  logic [DATA_W-1:0] ram_q_r;

  logic        accept;
  action_t     action;
  bank_state_t bank;
  logic        ram_on;

  logic [ROM_POS_W-1:0]     rom_pos;
  logic [RAM_POS_W-1:0]     ram_pos;
  logic [ROM_ADDR_BITS-1:0] rom_raddr;
  logic [RAM_ADDR_BITS-1:0] ram_addr;
  logic [LOAD_EXT_W-1:0]    load_ext;

  logic                     rom_re;
  logic                     rom_we;
  logic                     ram_re;
  logic                     ram_we;
  logic [RAM_ADDR_BITS-1:0] ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;

  assign in_ch.ready = !clearing_r && (!s1_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign action      = action_t'(in_ch.action);
  assign ram_on      = (bank.ram_enable == RAM_EN_KEY);

  rbm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (accept && (action == ACT_REG_WRITE)),
    .bus_address (in_ch.bus_address),
    .write_data  (in_ch.write_data),
    .bank        (bank)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_size_log2_r <= ROM_LOG2_RESET;
      ram_size_log2_r <= RAM_LOG2_RESET;
      has_rumble_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROM_SIZE_LOG2: rom_size_log2_r <= cfg_data;
        CFG_RAM_SIZE_LOG2: ram_size_log2_r <= cfg_data;
        CFG_HAS_RUMBLE:    has_rumble_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign rom_pos  = {bank.rom_bank_high, bank.rom_bank_low, in_ch.bus_address[13:0]};
  assign ram_pos  = {bank.ram_bank, in_ch.bus_address[12:0]};
  assign load_ext = LOAD_EXT_W'(in_ch.load_index);

  always_comb begin
    for (int i = 0; i < ROM_ADDR_BITS; i++) begin
      rom_raddr[i] = rom_pos[i] && (CFG_W'(i) < rom_size_log2_r);
    end
    for (int j = 0; j < RAM_ADDR_BITS; j++) begin
      ram_addr[j] = ram_pos[j] && (CFG_W'(j) < ram_size_log2_r);
    end
  end

  always_comb begin
    rom_re  = 1'b0;
    rom_we  = 1'b0;
    ram_re  = 1'b0;
    ram_we  = 1'b0;
    sel_nxt = SEL_ZERO;
    if (accept) begin
      case (action)
        ACT_ROM_READ: begin
          rom_re  = 1'b1;
          sel_nxt = SEL_ROM;
        end
        ACT_RAM_READ: begin
          ram_re  = ram_on;
          sel_nxt = ram_on ? SEL_RAM : SEL_OFF;
        end
        ACT_RAM_WRITE: ram_we = ram_on;
        ACT_ROM_LOAD:  rom_we = 1'b1;
        default: ;
      endcase
    end
  end

  assign ram_waddr = clearing_r ? clear_cnt_r : ram_addr;
  assign ram_wdata = clearing_r ? ZERO_DATA : in_ch.write_data;

  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom_mem[load_ext[ROM_ADDR_BITS-1:0]] <= in_ch.write_data;
    end
    if (rom_re) begin
      rom_q_r <= rom_mem[rom_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r || ram_we) begin
      ram_mem[ram_waddr] <= ram_wdata;
    end
    if (ram_re) begin
      ram_q_r <= ram_mem[ram_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clear_cnt_r <= '0;
    end else if (clearing_r) begin
      clear_cnt_r <= clear_cnt_r + 1'b1;
      if (clear_cnt_r == {RAM_ADDR_BITS{1'b1}}) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sel_r <= sel_nxt;
    end
  end

  assign out_ch.valid    = s1_valid_r;
  assign out_ch.motor_on = has_rumble_r && bank.ram_bank[RUMBLE_BIT];

  always_comb begin
    case (s1_sel_r)
      SEL_ROM: out_ch.read_data = rom_q_r;
      SEL_RAM: out_ch.read_data = ram_q_r;
      SEL_OFF: out_ch.read_data = RAM_OFF_DATA;
      default: out_ch.read_data = ZERO_DATA;
    endcase
  end

endmodule

// ===== rtl/rbm_checker.sv =====
// ----------------------------------------------------------------------------
// rbm_checker: bank mapper port checks
// Watches the top-level ports for handshake and pipeline consistency.
// ----------------------------------------------------------------------------
`include "rom_ram_bank_mapper_defines.svh"

module rbm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rbm_pkg::DATA_W-1:0] out_read_data
);
  import rbm_pkg::*;

  `RBM_ASSERT(a_accept_gives_result, clk, rst_n, in_valid && in_ready |=> out_valid)
  `RBM_ASSERT(a_taken_without_new_drains, clk, rst_n, out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
  `RBM_ASSERT(a_stalled_result_holds, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_read_data))
  `RBM_ASSERT_ALWAYS(a_reset_blocks_input, clk, !rst_n |=> !in_ready)

endmodule

bind rom_ram_bank_mapper rbm_checker u_rbm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_read_data (out_ch.read_data)
);

// ===== sim/tb_rom_ram_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// tb_rom_ram_bank_mapper: bank mapper testbench
// Drives bus accesses through the input channel under random idling on both
// sides and predicts every result with a behavioral copy of the mapper
// state. Each configuration phase starts only once the block is idle.
// ----------------------------------------------------------------------------
module tb_rom_ram_bank_mapper;
  timeunit 1ns;
  timeprecision 1ps;

  import rbm_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = ACTION_W'(ACT_ROM_LOAD + 1);
  localparam logic [ACTION_W-1:0] ACT_LAST_UNUSED  = '1;
  localparam int                  HOLD_CYCLES      = 80;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [BUS_W-1:0]    addr;
    logic [DATA_W-1:0]   data;
    logic [LOAD_W-1:0]   load;
  } bus_access_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              motor_on;
  } mapper_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             cfg_we = 1'b0;
  cfg_index_t       cfg_index = CFG_ROM_SIZE_LOG2;
  logic [CFG_W-1:0] cfg_data = '0;

  logic        drv_valid = 1'b0;
  bus_access_t drv_item = '0;
  logic        rcv_ready = 1'b0;
  logic        in_accepted = 1'b0;

  rbm_in_if  in_ch ();
  rbm_out_if out_ch ();

  assign in_ch.valid       = drv_valid;
  assign in_ch.action      = drv_item.act;
  assign in_ch.bus_address = drv_item.addr;
  assign in_ch.write_data  = drv_item.data;
  assign in_ch.load_index  = drv_item.load;
  assign out_ch.ready      = rcv_ready;

  rom_ram_bank_mapper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bus_access_t    access_q[$];
  mapper_result_t result_q[$];
  int n_pushed = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int send_idle_pct = 35;
  int recv_idle_pct = 68;
  int hold_seq = 0;

  logic [CFG_W-1:0] cfg_rom_log2 = ROM_LOG2_RESET;
  logic [CFG_W-1:0] cfg_ram_log2 = RAM_LOG2_RESET;
  logic             cfg_rumble = 1'b0;

  logic [3:0]        mdl_ram_en = '0;
  logic [7:0]        mdl_rom_lo = ROM_LOW_RESET;
  logic              mdl_rom_hi = 1'b0;
  logic [3:0]        mdl_ram_bank = '0;
  logic [DATA_W-1:0] rom_image [int];
  logic [DATA_W-1:0] ram_image [int];

  logic [7:0] plan_rom_lo = ROM_LOW_RESET;
  logic       plan_rom_hi = 1'b0;
  bit         rom_loaded [int];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] size_mask(logic [CFG_W-1:0] lg, int lim);
    int n;
    n = (int'(lg) > lim) ? lim : int'(lg);
    return (32'd1 << n) - 32'd1;
  endfunction

  function automatic int plan_rom_pos(logic [BUS_W-1:0] addr);
    return int'(32'({plan_rom_hi, plan_rom_lo, addr[13:0]}) &
                size_mask(cfg_rom_log2, RBM_ROM_ADDR_BITS));
  endfunction

  task automatic compute_bus_response(input bus_access_t a);
    mapper_result_t r;
    logic [31:0]    pos;
    logic           enabled;
    r.read_data = ZERO_DATA;
    enabled = (mdl_ram_en == RAM_EN_KEY);
    case (a.act)
      ACT_REG_WRITE: begin
        if (a.addr < ADDR_RAM_EN_END) mdl_ram_en = a.data[3:0];
        else if (a.addr < ADDR_ROM_LOW_END) mdl_rom_lo = a.data;
        else if (a.addr < ADDR_ROM_HI_END) mdl_rom_hi = a.data[0];
        else if (a.addr < ADDR_RAM_BK_END) mdl_ram_bank = a.data[3:0];
      end
      ACT_ROM_READ: begin
        pos = 32'({mdl_rom_hi, mdl_rom_lo, a.addr[13:0]}) &
              size_mask(cfg_rom_log2, RBM_ROM_ADDR_BITS);
        r.read_data = rom_image.exists(int'(pos)) ? rom_image[int'(pos)] : ZERO_DATA;
      end
      ACT_RAM_READ: begin
        pos = 32'({mdl_ram_bank, a.addr[12:0]}) & size_mask(cfg_ram_log2, RBM_RAM_ADDR_BITS);
        if (!enabled) r.read_data = RAM_OFF_DATA;
        else if (ram_image.exists(int'(pos))) r.read_data = ram_image[int'(pos)];
      end
      ACT_RAM_WRITE: begin
        pos = 32'({mdl_ram_bank, a.addr[12:0]}) & size_mask(cfg_ram_log2, RBM_RAM_ADDR_BITS);
        if (enabled) ram_image[int'(pos)] = a.data;
      end
      ACT_ROM_LOAD: rom_image[int'(a.load)] = a.data;
      default: ;
    endcase
    r.motor_on = cfg_rumble & mdl_ram_bank[RUMBLE_BIT];
    result_q.push_back(r);
  endtask

  // A ROM read of a location never loaded is preceded by a load of it.
  task automatic push_item(logic [ACTION_W-1:0] act, logic [BUS_W-1:0] addr,
                           logic [DATA_W-1:0] data, logic [LOAD_W-1:0] load);
    bus_access_t a;
    int          pos;
    if (act == ACT_ROM_READ) begin
      pos = plan_rom_pos(addr);
      if (!rom_loaded.exists(pos)) begin
        a = '{act: ACT_ROM_LOAD, addr: addr, data: DATA_W'($urandom), load: LOAD_W'(pos)};
        access_q.push_back(a);
        rom_loaded[pos] = 1'b1;
        n_pushed++;
      end
    end else if (act == ACT_ROM_LOAD) begin
      rom_loaded[int'(load)] = 1'b1;
    end else if (act == ACT_REG_WRITE && addr >= ADDR_RAM_EN_END) begin
      if (addr < ADDR_ROM_LOW_END) plan_rom_lo = data;
      else if (addr < ADDR_ROM_HI_END) plan_rom_hi = data[0];
    end
    a = '{act: act, addr: addr, data: data, load: load};
    access_q.push_back(a);
    n_pushed++;
  endtask

  function automatic logic [BUS_W-1:0] ram_addr();
    if ($urandom_range(0, 9) == 0) return BUS_W'($urandom);
    return {3'($urandom), 13'($urandom_range(0, 15))};
  endfunction

  function automatic logic [BUS_W-1:0] rom_addr();
    if ($urandom_range(0, 9) < 3) return BUS_W'($urandom);
    return {2'($urandom), 14'($urandom_range(0, 15))};
  endfunction

  task automatic gen_random(int count);
    int start;
    int kind;
    logic [DATA_W-1:0] en;
    start = n_pushed;
    while (n_pushed - start < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        en = ($urandom_range(0, 4) != 0) ? {4'($urandom), RAM_EN_KEY} : DATA_W'($urandom);
        push_item(ACT_REG_WRITE, {3'b000, 13'($urandom)}, en, LOAD_W'($urandom));
        if ($urandom_range(0, 1))
          push_item(ACT_REG_WRITE, {3'b010, 13'($urandom)}, DATA_W'($urandom),
                    LOAD_W'($urandom));
        repeat ($urandom_range(2, 8)) begin
          if ($urandom_range(0, 1))
            push_item(ACT_RAM_WRITE, ram_addr(), DATA_W'($urandom), LOAD_W'($urandom));
          else
            push_item(ACT_RAM_READ, ram_addr(), DATA_W'($urandom), LOAD_W'($urandom));
        end
      end else if (kind < 75) begin
        push_item(ACT_REG_WRITE, {4'b0010, 12'($urandom)}, DATA_W'($urandom),
                  LOAD_W'($urandom));
        if ($urandom_range(0, 1))
          push_item(ACT_REG_WRITE, {4'b0011, 12'($urandom)}, DATA_W'($urandom),
                    LOAD_W'($urandom));
        repeat ($urandom_range(2, 6)) begin
          if ($urandom_range(0, 9) < 4)
            push_item(ACT_ROM_LOAD, BUS_W'($urandom), DATA_W'($urandom), LOAD_W'($urandom));
          else
            push_item(ACT_ROM_READ, rom_addr(), DATA_W'($urandom), LOAD_W'($urandom));
        end
      end else begin
        push_item(ACTION_W'($urandom), BUS_W'($urandom), DATA_W'($urandom),
                  LOAD_W'($urandom));
      end
    end
  endtask

  task automatic set_config(logic [CFG_W-1:0] rom_lg, logic [CFG_W-1:0] ram_lg, logic rumble);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ROM_SIZE_LOG2;
    cfg_data <= rom_lg;
    @(negedge clk);
    cfg_index <= CFG_RAM_SIZE_LOG2;
    cfg_data <= ram_lg;
    @(negedge clk);
    cfg_index <= CFG_HAS_RUMBLE;
    cfg_data <= CFG_W'(rumble);
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_rom_log2 = rom_lg;
    cfg_ram_log2 = ram_lg;
    cfg_rumble = rumble;
  endtask

  task automatic wait_until_idle();
    while (!(n_accepted == n_pushed && result_q.size() == 0)) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!(drv_valid && !in_accepted)) begin
      if (rst_n && access_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_item <= access_q.pop_front();
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  int hold_seen = 0;
  int hold_cnt = 0;

  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      rcv_ready <= 1'b0;
    end else begin
      rcv_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    mapper_result_t want;
    in_accepted = rst_n && in_ch.valid && in_ch.ready;
    if (in_accepted) begin
      n_accepted++;
      compute_bus_response('{act: in_ch.action, addr: in_ch.bus_address,
                             data: in_ch.write_data, load: in_ch.load_index});
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (result_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected transaction: expected none, actual read_data %h motor_on %b",
                 $time, out_ch.read_data, out_ch.motor_on);
      end else begin
        want = result_q.pop_front();
        if (out_ch.read_data !== want.read_data) begin
          n_errors++;
          $display("%0t: read_data mismatch: expected %h, actual %h",
                   $time, want.read_data, out_ch.read_data);
        end
        if (out_ch.motor_on !== want.motor_on) begin
          n_errors++;
          $display("%0t: motor_on mismatch: expected %b, actual %b",
                   $time, want.motor_on, out_ch.motor_on);
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    set_config(5'd20, 5'd17, 1'b1);
    push_item(ACT_RAM_READ, 16'hA000, 8'h00, 20'h00000);
    push_item(ACT_RAM_WRITE, 16'hA000, 8'h55, 20'h00000);
    push_item(ACT_REG_WRITE, 16'h0000, 8'h0A, 20'h00000);
    push_item(ACT_RAM_READ, 16'hA000, 8'h00, 20'h00000);
    push_item(ACT_ROM_LOAD, 16'h0000, 8'hA5, 20'hFFFFF);
    push_item(ACT_ROM_LOAD, 16'hFFFF, 8'h5A, 20'h00000);
    push_item(ACT_REG_WRITE, ADDR_RAM_EN_END, 8'hFF, 20'h00000);
    push_item(ACT_REG_WRITE, ADDR_ROM_HI_END - 1'b1, 8'hFF, 20'h00000);
    push_item(ACT_ROM_READ, 16'h7FFF, 8'h00, 20'h00000);
    push_item(ACT_REG_WRITE, ADDR_ROM_LOW_END - 1'b1, 8'h00, 20'h00000);
    push_item(ACT_REG_WRITE, ADDR_ROM_LOW_END, 8'hFE, 20'h00000);
    push_item(ACT_ROM_READ, 16'h4000, 8'h00, 20'h00000);
    push_item(ACT_REG_WRITE, ADDR_RAM_BK_END, 8'h0F, 20'h00000);
    push_item(ACT_REG_WRITE, 16'hFFFF, 8'hAA, 20'h00000);
    push_item(ACT_REG_WRITE, ADDR_RAM_BK_END - 1'b1, 8'hF8, 20'h00000);
    push_item(ACT_RAM_WRITE, 16'hBFFF, 8'hFF, 20'h00000);
    push_item(ACT_RAM_READ, 16'hBFFF, 8'h00, 20'h00000);
    push_item(ACT_RAM_READ, 16'hA000, 8'h00, 20'h00000);
    push_item(ACT_REG_WRITE, ADDR_ROM_HI_END, 8'h00, 20'h00000);
    push_item(ACT_RAM_WRITE, 16'hFFFF, 8'h01, 20'h00000);
    push_item(ACT_RAM_READ, 16'hBFFF, 8'h00, 20'h00000);
    push_item(ACT_REG_WRITE, ADDR_RAM_EN_END - 1'b1, 8'hFA, 20'h00000);
    push_item(ACT_RAM_READ, 16'hA000, 8'h00, 20'h00000);
    push_item(ACT_REG_WRITE, 16'h0000, 8'h0B, 20'h00000);
    push_item(ACT_RAM_READ, 16'hBFFF, 8'h00, 20'h00000);
    push_item(ACT_FIRST_UNUSED, 16'h0000, 8'h00, 20'h00000);
    push_item(ACT_LAST_UNUSED, 16'hFFFF, 8'hFF, 20'hFFFFF);
    gen_random(105);
    wait_until_idle();

    set_config(5'd15, 5'd11, 1'b0);
    gen_random(105);
    wait_until_idle();

    // Swap the idle rates; a long receiver stall lets the block back up.
    send_idle_pct = 68;
    recv_idle_pct = 35;
    set_config(5'd31, 5'd31, 1'b1);
    gen_random(50);
    hold_seq++;
    gen_random(55);
    wait_until_idle();

    set_config(5'd0, 5'd0, 1'b1);
    gen_random(50);
    wait_until_idle();
    gen_random(55);
    wait_until_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(5'd18, 5'd14, 1'b0);
    gen_random(105);
    wait_until_idle();

    set_config(5'd20, 5'd17, 1'b1);
    gen_random(105);
    wait_until_idle();

    if (n_errors == 0 && result_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0t: %0d mismatches, %0d results never arrived",
               $time, n_errors, result_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("%0t: timeout with %0d of %0d transactions accepted",
             $time, n_accepted, n_pushed);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rbm_pkg.sv
rtl/rbm_if.sv
rtl/rbm_regs.sv
rtl/rom_ram_bank_mapper.sv
rtl/rbm_checker.sv
sim/tb_rom_ram_bank_mapper.sv
